@@ rtl/prss_pkg.sv @@
// ----------------------------------------------------------------------------
// prss_pkg
// shared types and constants of the pll rate slew sequencer
// ----------------------------------------------------------------------------
package prss_pkg;

	localparam int RATE_W     = 30;
	localparam int TARGET_W   = 32;
	localparam int SENSE_W    = 10;
	localparam int CODE_W     = 8;
	localparam int CUR_W      = 11;          // current rate in mhz, up to 5 * 214
	localparam int QUO_W      = 8;           // rate in 5 mhz units
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int ADDR_LSB   = 2;

	localparam int STEP_HZ    = 5000000;
	localparam int MHZ_HZ     = 1000000;
	localparam int MASK30     = (1 << 30) - 1;
	localparam int QUO_RND_MAX = (MASK30 - STEP_HZ) / STEP_HZ;

	localparam int MIN_RATE_RST = 5000000;
	localparam int MAX_RATE_RST = 1020000000;

	localparam int RESULT_CAP    = 16;
	localparam int MAX_STEPS_DEF = 16;
	localparam int CNT_W         = $clog2(RESULT_CAP + 1);

	// floor(x / 5e6) for a 30-bit x: 5e6 = 2^6 * 5^7, so drop six bits and
	// take (y * Q5_RECIP) >> Q5_SHIFT, exact for every 24-bit y
	localparam int Q5_DROP   = 6;
	localparam int Q5_RECIP  = 28147498;
	localparam int Q5_SHIFT  = 41;
	localparam int Q5_PROD_W = 49;

	// floor(x / 25) for x below 2^13 as (x * RECIP_25) >> RECIP_SHIFT
	localparam int DIV_X_W      = 13;
	localparam int RECIP_25     = 5243;
	localparam int RECIP_SHIFT  = 17;
	localparam int RECIP_PROD_W = 26;
	localparam int DIV_Q_W      = 9;

	localparam int CMD_DEPTH = 2;
	localparam int RSP_DEPTH = 2;

	// register select, taken from paddr[ADDR_LSB]
	localparam logic REG_MIN_RATE = 1'b0;
	localparam logic REG_MAX_RATE = 1'b1;

	typedef struct packed {
		logic [TARGET_W-1:0] target_hz;
		logic [SENSE_W-1:0]  sensed_mhz;
	} req_t;

	typedef struct packed {
		logic [CODE_W-1:0] multiplier_code;
		logic [RATE_W-1:0] step_rate_hz;
		logic [RATE_W-1:0] rounded_rate_hz;
		logic              write_valid;
		logic              error_flag;
		logic              last;
	} rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [QUO_W-1:0]   target_q5;
		logic [RATE_W-1:0]  rounded_hz;
		logic [SENSE_W-1:0] sensed_mhz;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RSP_W = $bits(rsp_t);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} fstate_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CHECK,
		B_CALC,
		B_EMIT
	} bstate_t;

endpackage

@@ rtl/pll_rate_slew_sequencer.sv @@
// ----------------------------------------------------------------------------
// pll_rate_slew_sequencer
// turns a pll rate request into a run of slew-limited multiplier writes
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  request   | push / full        | req : target_hz, sensed_mhz
//  result    | empty / pop        | rsp : multiplier_code .. last
//  config    | psel/penable/pwrite| min_rate_hz at 0x0, max_rate_hz at 0x4
//
//  the front works one request at a time, taking no new one before the hand-off,
//  in three states (accept, one reciprocal multiply into 5 mhz units, hand-off);
//  a full command queue holds it in the hand-off. the back first checks the
//  request, then passes a calc and an emit state for each step
//  reset clears both queues and loads the default min and max rates
//  a full result queue stalls the back; the command queue lets the front
//  prepare the next request meanwhile
//
module pll_rate_slew_sequencer #(
	parameter int MAX_STEPS = prss_pkg::MAX_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          push,
	output logic                          full,
	input  prss_pkg::req_t                req,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output prss_pkg::rsp_t                rsp,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [prss_pkg::PADDR_W-1:0]  paddr,
	input  logic [prss_pkg::PDATA_W-1:0]  pwdata,
	output logic [prss_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import prss_pkg::*;

	// writes per run, at least one and never beyond the result cap
	localparam int STEP_LIMIT = (MAX_STEPS < 1) ? 1 :
	                            ((MAX_STEPS > RESULT_CAP) ? RESULT_CAP : MAX_STEPS);

	logic [RATE_W-1:0] min_rate_q;
	logic [RATE_W-1:0] max_rate_q;
	logic              cfg_wr;

	cmd_t              cmd_in;
	logic              cmd_push;
	logic              cmd_full;
	logic [CMD_W-1:0]  cmd_raw;
	cmd_t              cmd_out;
	logic              cmd_empty;
	logic              cmd_pop;

	rsp_t              rsp_in;
	logic              rsp_push;
	logic              rsp_full;
	logic [RSP_W-1:0]  rsp_raw;

	// ---- configuration registers ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= RATE_W'(MIN_RATE_RST);
			max_rate_q <= RATE_W'(MAX_RATE_RST);
		end else if (cfg_wr) begin
			unique case (paddr[ADDR_LSB])
				REG_MIN_RATE: min_rate_q <= pwdata[RATE_W-1:0];
				REG_MAX_RATE: max_rate_q <= pwdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_LSB])
			REG_MIN_RATE: prdata = PDATA_W'(min_rate_q);
			REG_MAX_RATE: prdata = PDATA_W'(max_rate_q);
			default:      prdata = '0;
		endcase
	end

	// ---- front: clamp, divide into 5 mhz units, round ----
	prss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.min_rate (min_rate_q),
		.max_rate (max_rate_q),
		.cmd      (cmd_in),
		.cmd_push (cmd_push),
		.cmd_full (cmd_full)
	);

	// ---- hand-off queue between front and back ----
	prss_queue #(
		.DATA_W (CMD_W),
		.DEPTH  (CMD_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_raw),
		.empty  (cmd_empty)
	);

	assign cmd_out = cmd_t'(cmd_raw);

	// ---- back: slew sequencer ----
	prss_back #(
		.STEP_LIMIT (STEP_LIMIT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp_in),
		.rsp_push  (rsp_push),
		.rsp_full  (rsp_full)
	);

	// ---- result queue, parts the back from the consumer ----
	prss_queue #(
		.DATA_W (RSP_W),
		.DEPTH  (RSP_DEPTH)
	) u_rsp_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rsp_push),
		.wdata  (rsp_in),
		.full   (rsp_full),
		.rd     (pop),
		.rdata  (rsp_raw),
		.empty  (empty)
	);

	assign rsp = rsp_t'(rsp_raw);

	// ---- checks ----
	// every error ends the run
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.error_flag) |-> rsp.last)
		else $error("error result without last");

	// a result with no write carries a zero code and closes the run
	a_nowrite_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !rsp.write_valid) |-> (rsp.last && rsp.multiplier_code == '0))
		else $error("no-write result malformed");

	// the back only pushes into the result queue when it has room
	a_rsp_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push |-> !rsp_full)
		else $error("result queue overflow");

	// the front only hands a request over when the queue has room
	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");

endmodule

@@ rtl/prss_queue.sv @@
// ----------------------------------------------------------------------------
// prss_queue
// small register queue with count, used between the stages and at the output
// ----------------------------------------------------------------------------
module prss_queue #(
	parameter int DATA_W = prss_pkg::CMD_W,
	parameter int DEPTH  = prss_pkg::CMD_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              rd,
	output logic [DATA_W-1:0] rdata,
	output logic              empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/prss_front.sv @@
// ----------------------------------------------------------------------------
// prss_front
// clamps a request, divides it into 5 mhz units and rounds to nearest step
// ----------------------------------------------------------------------------
module prss_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  prss_pkg::req_t                  req,
	input  logic [prss_pkg::RATE_W-1:0]     min_rate,
	input  logic [prss_pkg::RATE_W-1:0]     max_rate,
	output prss_pkg::cmd_t                  cmd,
	output logic                            cmd_push,
	input  logic                            cmd_full
);
	import prss_pkg::*;

	fstate_t              state_q;
	fstate_t              state_d;
	logic [RATE_W-1:0]    rate_q;
	logic [QUO_W-1:0]     quo_q;
	logic [SENSE_W-1:0]   sensed_q;
	logic [TARGET_W-1:0]  lo_clamp;
	logic [TARGET_W-1:0]  hi_clamp;
	logic [Q5_PROD_W-1:0] quo_prod;
	logic [QUO_W-1:0]     quo;
	logic [RATE_W-1:0]    rem;
	logic                 take;
	logic                 round_up;

	assign take = push && !full;

	// raise to min first, then lower to max, so max wins when they cross
	always_comb begin
		lo_clamp = (req.target_hz < TARGET_W'(min_rate)) ? TARGET_W'(min_rate) : req.target_hz;
		hi_clamp = (lo_clamp > TARGET_W'(max_rate)) ? TARGET_W'(max_rate) : lo_clamp;
	end

	// quotient by 5 mhz via reciprocal multiply, remainder from it
	assign quo_prod = Q5_PROD_W'(rate_q[RATE_W-1:Q5_DROP]) * Q5_PROD_W'(Q5_RECIP);
	assign quo      = quo_prod[Q5_SHIFT +: QUO_W];
	assign rem      = rate_q - RATE_W'(quo_q) * RATE_W'(STEP_HZ);
	assign round_up = (rem > (RATE_W'(STEP_HZ) - rem)) && (quo_q <= QUO_W'(QUO_RND_MAX));

	always_comb begin
		state_d  = state_q;
		full     = (state_q != F_IDLE);
		cmd_push = 1'b0;
		cmd.target_q5  = quo_q + QUO_W'(round_up);
		cmd.rounded_hz = rate_q - rem + (round_up ? RATE_W'(STEP_HZ) : '0);
		cmd.sensed_mhz = sensed_q;
		unique case (state_q)
			F_IDLE: begin
				if (push) begin
					state_d = F_DIV;
				end
			end
			F_DIV: begin
				state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!cmd_full) begin
					cmd_push = 1'b1;
					state_d  = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rate_q   <= RATE_W'(hi_clamp);
			sensed_q <= req.sensed_mhz;
		end else if (state_q == F_DIV) begin
			quo_q <= quo;
		end
	end

endmodule

@@ rtl/prss_back.sv @@
// ----------------------------------------------------------------------------
// prss_back
// walks the pll from the sensed rate to the target in slew-limited steps
// ----------------------------------------------------------------------------
module prss_back #(
	parameter int STEP_LIMIT = prss_pkg::MAX_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  prss_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	output prss_pkg::rsp_t rsp,
	output logic           rsp_push,
	input  logic           rsp_full
);
	import prss_pkg::*;

	bstate_t                 state_q;
	bstate_t                 state_d;
	logic [CUR_W-1:0]        cur_q;
	logic [QUO_W-1:0]        tq_q;
	logic [RATE_W-1:0]       rounded_q;
	logic [CNT_W-1:0]        n_q;
	logic [QUO_W-1:0]        m_q;
	logic                    up_q;

	logic [CUR_W-1:0]        tgt_mhz;
	logic [CUR_W-1:0]        m_mhz;
	logic                    up_d;
	logic [DIV_X_W-1:0]      div_x;
	logic [RECIP_PROD_W-1:0] div_prod;
	logic [DIV_Q_W-1:0]      div_q;
	logic [DIV_Q_W-1:0]      div_qc;
	logic [QUO_W-1:0]        m_d;
	logic                    stall;
	logic                    hit;
	logic                    limit_hit;

	assign tgt_mhz = CUR_W'(tq_q) * CUR_W'(5);
	assign m_mhz   = CUR_W'(m_q) * CUR_W'(5);
	assign up_d    = tgt_mhz > cur_q;

	// next step in 5 mhz units: up is floor(6c/25), down is ceil(4c/25)
	always_comb begin
		div_x    = up_d ? DIV_X_W'(cur_q) * DIV_X_W'(6)
		                : DIV_X_W'(cur_q) * DIV_X_W'(4) + DIV_X_W'(24);
		div_prod = RECIP_PROD_W'(div_x) * RECIP_PROD_W'(RECIP_25);
		div_q    = div_prod[RECIP_SHIFT +: DIV_Q_W];
		if ((DIV_X_W + 1)'(div_x) >= (DIV_X_W + 1)'(div_q) * (DIV_X_W + 1)'(25)
		                             + (DIV_X_W + 1)'(25)) begin
			div_qc = div_q + 1'b1;
		end else begin
			div_qc = div_q;
		end
		if (up_d) begin
			m_d = (div_qc < DIV_Q_W'(tq_q)) ? QUO_W'(div_qc) : tq_q;
		end else begin
			m_d = (div_qc > DIV_Q_W'(tq_q)) ? QUO_W'(div_qc) : tq_q;
		end
	end

	assign stall     = up_q ? (m_mhz <= cur_q) : (m_mhz >= cur_q);
	assign hit       = (m_q == tq_q);
	assign limit_hit = (int'(n_q) + 1) >= STEP_LIMIT;

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		rsp_push = 1'b0;
		rsp      = '0;
		rsp.rounded_rate_hz = rounded_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = B_CHECK;
				end
			end
			B_CHECK: begin
				rsp.last = 1'b1;
				if (cur_q == '0) begin
					rsp.error_flag = 1'b1;
					rsp_push       = !rsp_full;
					if (!rsp_full) begin
						state_d = B_IDLE;
					end
				end else if (cur_q == tgt_mhz) begin
					rsp.step_rate_hz = rounded_q;
					rsp_push         = !rsp_full;
					if (!rsp_full) begin
						state_d = B_IDLE;
					end
				end else begin
					state_d = B_CALC;
				end
			end
			B_CALC: begin
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (stall) begin
					rsp.step_rate_hz = RATE_W'(cur_q) * RATE_W'(MHZ_HZ);
					rsp.error_flag   = 1'b1;
					rsp.last         = 1'b1;
				end else begin
					rsp.multiplier_code = m_q - 1'b1;
					rsp.step_rate_hz    = RATE_W'(m_q) * RATE_W'(STEP_HZ);
					rsp.write_valid     = 1'b1;
					if (hit) begin
						rsp.last = 1'b1;
					end else if (limit_hit) begin
						rsp.error_flag = 1'b1;
						rsp.last       = 1'b1;
					end
				end
				if (!rsp_full) begin
					rsp_push = 1'b1;
					state_d  = rsp.last ? B_IDLE : B_CALC;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				n_q <= '0;
			end else if (rsp_push && !rsp.last && state_q == B_EMIT) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q     <= CUR_W'(cmd.sensed_mhz);
			tq_q      <= cmd.target_q5;
			rounded_q <= cmd.rounded_hz;
		end else if (state_q == B_CALC) begin
			m_q  <= m_d;
			up_q <= up_d;
		end else if (state_q == B_EMIT && rsp_push && !rsp.last) begin
			cur_q <= m_mhz;
		end
	end

endmodule

@@ sim/pll_rate_slew_sequencer_test.sv @@
// ----------------------------------------------------------------------------
// pll_rate_slew_sequencer_test
// self-checking bench for the pll rate slew sequencer
// ----------------------------------------------------------------------------
// rate requests go in through the push/full queue side and the results come back
// through empty/pop. a scoreboard object works out the full run of multiplier
// writes for every accepted request and checks each result against the oldest
// one still due. the rate limits are reprogrammed over apb between phases and
// read back. both sides idle at random, the receiver holds off for a long stretch
// once, and the sender drains the block part-way through one phase.
// ----------------------------------------------------------------------------
module pll_rate_slew_sequencer_test;
	import prss_pkg::*;

	class slew_scoreboard;
		logic [RATE_W-1:0] min_rate;
		logic [RATE_W-1:0] max_rate;
		int                budget;
		rsp_t              slew_due[$];
		int                mismatches;
		int                requests;
		int                results;
		int                writes;
		int                flagged;
		int                no_change;

		function new(int steps);
			min_rate   = RATE_W'(MIN_RATE_RST);
			max_rate   = RATE_W'(MAX_RATE_RST);
			budget     = steps;
			mismatches = 0;
			requests   = 0;
			results    = 0;
			writes     = 0;
			flagged    = 0;
			no_change  = 0;
		endfunction

		function int pending();
			return slew_due.size();
		endfunction

		task report(string what, longint unsigned got_v, longint unsigned want_v);
			mismatches++;
			$display("mismatch: %s got %0d want %0d", what, got_v, want_v);
		endtask

		// clamp to the limits, then round to the nearest 5 mhz step
		function longint unsigned snap_rate(logic [TARGET_W-1:0] t);
			longint unsigned rate;
			longint unsigned off;
			rate = t;
			if (rate < min_rate) rate = min_rate;
			if (rate > max_rate) rate = max_rate;
			off  = rate % STEP_HZ;
			rate = rate - off;
			if (off > STEP_HZ - off && rate + STEP_HZ <= MASK30) rate += STEP_HZ;
			return rate;
		endfunction

		function void queue_result(logic [CODE_W-1:0] code, longint unsigned step_hz,
				longint unsigned rounded_hz, bit wv, bit err, bit fin);
			rsp_t e;
			e.multiplier_code = code;
			e.step_rate_hz    = RATE_W'(step_hz);
			e.rounded_rate_hz = RATE_W'(rounded_hz);
			e.write_valid     = wv;
			e.error_flag      = err;
			e.last            = fin;
			slew_due.push_back(e);
		endfunction

		// current and target rates in khz while walking, as the pll is assumed to land on each step
		function void note_request(req_t r);
			longint unsigned rounded;
			longint unsigned tgt;
			longint unsigned cur;
			longint unsigned nt;
			longint unsigned stp;
			longint unsigned d;
			longint unsigned nt_khz;
			logic [CODE_W-1:0] code;
			bit up;
			requests++;
			rounded = snap_rate(r.target_hz);
			tgt     = rounded / 1000;
			cur     = longint'(r.sensed_mhz) * 1000;
			if (cur == 0) begin
				queue_result('0, 0, rounded, 1'b0, 1'b1, 1'b1);
				return;
			end
			if (cur == tgt) begin
				queue_result('0, rounded, rounded, 1'b0, 1'b0, 1'b1);
				return;
			end
			for (int n = 0; n < budget; n++) begin
				up = tgt > cur;
				if (up) begin
					stp = (6 * cur) / 5 - cur;
					d   = tgt - cur;
					nt  = cur + (d < stp ? d : stp);
					nt  = ((nt * 1000) / STEP_HZ) * STEP_HZ;
				end else begin
					stp = cur - (4 * cur) / 5;
					d   = cur - tgt;
					nt  = cur - (d < stp ? d : stp);
					nt  = ((nt * 1000 + STEP_HZ - 1) / STEP_HZ) * STEP_HZ;
				end
				nt_khz = nt / 1000;
				// no progress towards the target
				if (up ? (nt_khz <= cur) : (nt_khz >= cur)) begin
					queue_result('0, cur * 1000, rounded, 1'b0, 1'b1, 1'b1);
					return;
				end
				code = CODE_W'(nt / STEP_HZ - 1);
				cur  = nt_khz;
				if (cur == tgt || n + 1 >= budget) begin
					queue_result(code, nt, rounded, 1'b1, cur != tgt, 1'b1);
					return;
				end
				queue_result(code, nt, rounded, 1'b1, 1'b0, 1'b0);
			end
		endfunction

		task check_result(rsp_t got);
			rsp_t want;
			if (slew_due.size() == 0) begin
				report("result with nothing due, step_rate_hz", got.step_rate_hz, 0);
				return;
			end
			want = slew_due.pop_front();
			results++;
			writes    += want.write_valid;
			flagged   += want.error_flag;
			no_change += !want.write_valid && !want.error_flag;
			if (got.multiplier_code !== want.multiplier_code)
				report("multiplier_code", got.multiplier_code, want.multiplier_code);
			if (got.step_rate_hz !== want.step_rate_hz)
				report("step_rate_hz", got.step_rate_hz, want.step_rate_hz);
			if (got.rounded_rate_hz !== want.rounded_rate_hz)
				report("rounded_rate_hz", got.rounded_rate_hz, want.rounded_rate_hz);
			if (got.write_valid !== want.write_valid)
				report("write_valid", got.write_valid, want.write_valid);
			if (got.error_flag !== want.error_flag)
				report("error_flag", got.error_flag, want.error_flag);
			if (got.last !== want.last)
				report("last", got.last, want.last);
		endtask
	endclass

	// step budget as the block applies it: at least one, at most the result cap
	localparam int SLEW_BUDGET = (MAX_STEPS_DEF < 1) ? 1 :
		(MAX_STEPS_DEF > RESULT_CAP ? RESULT_CAP : MAX_STEPS_DEF);
	// settling margin after the last expected result, to cover any straggler
	localparam int SETTLE_CYCLES = 40;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	req_t               req;
	logic               empty;
	logic               pop;
	rsp_t               rsp;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	slew_scoreboard sb;
	bit             pace_free;       // both sides run without gaps when set
	int             rx_hold_cycles;  // one-off long hold-off picked up by the receiver
	int             settings;

	pll_rate_slew_sequencer #(
		.MAX_STEPS(MAX_STEPS_DEF)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int draw_gap();
		return pace_free ? 0 : int'($urandom_range(0, 17));
	endfunction

	// random request, mostly sensible targets around the current limits
	function automatic req_t draw_request();
		req_t            r;
		int              kind;
		int              s;
		int unsigned     lo;
		int unsigned     hi;
		longint unsigned snapped;
		lo   = (sb.min_rate < sb.max_rate) ? sb.min_rate : sb.max_rate;
		hi   = (sb.min_rate < sb.max_rate) ? sb.max_rate : sb.min_rate;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			// ordinary slew, sensed rate either anywhere or near the target
			r.target_hz = $urandom_range(lo > 10_000_000 ? lo - 10_000_000 : 0,
				hi + 10_000_000);
			if ($urandom_range(0, 1)) begin
				r.sensed_mhz = SENSE_W'($urandom_range(1, 1023));
			end else begin
				s = int'(r.target_hz / MHZ_HZ) + int'($urandom_range(0, 120)) - 60;
				if (s < 1) s = 1;
				if (s > 1023) s = 1023;
				r.sensed_mhz = SENSE_W'(s);
			end
		end else if (kind < 65) begin
			// pll already sitting on the rounded target
			r.target_hz  = $urandom_range(lo, hi);
			snapped      = sb.snap_rate(r.target_hz) / MHZ_HZ;
			r.sensed_mhz = (snapped > 1023) ? SENSE_W'(1023) : SENSE_W'(snapped);
		end else if (kind < 75) begin
			// dead or nearly dead sense reading
			r.target_hz  = $urandom_range(lo, hi);
			r.sensed_mhz = SENSE_W'($urandom_range(0, 4));
		end else if (kind < 90) begin
			r.target_hz  = $urandom();
			r.sensed_mhz = SENSE_W'($urandom_range(0, 1023));
		end else begin
			// on or next to a half-step rounding boundary
			r.target_hz  = $urandom_range(1, 214) * STEP_HZ - 2_500_000
				+ $urandom_range(0, 2) - 1;
			r.sensed_mhz = SENSE_W'($urandom_range(1, 1023));
		end
		return r;
	endfunction

	// offer one request, push stays high across back-to-back items
	task automatic send_request(input logic [TARGET_W-1:0] t, input logic [SENSE_W-1:0] s);
		int   gap;
		req_t r;
		gap          = draw_gap();
		r.target_hz  = t;
		r.sensed_mhz = s;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full);
		sb.note_request(r);
	endtask

	task automatic run_requests(input int count);
		req_t r;
		repeat (count) begin
			r = draw_request();
			send_request(r.target_hz, r.sensed_mhz);
		end
	endtask

	// drop push and wait until every expected result has been taken
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one apb transfer: setup, then access until pready
	task automatic apb_access(input logic wr, input logic sel,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'(sel) << ADDR_LSB;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_rate(input logic sel, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b1, sel, value, rd);
		apb_access(1'b0, sel, '0, rd);
		if (rd[RATE_W-1:0] !== value[RATE_W-1:0])
			sb.report("rate register readback", rd[RATE_W-1:0], value[RATE_W-1:0]);
	endtask

	// only called with the block idle
	task automatic set_rates(input logic [PDATA_W-1:0] lo, input logic [PDATA_W-1:0] hi);
		program_rate(REG_MIN_RATE, lo);
		program_rate(REG_MAX_RATE, hi);
		sb.min_rate = lo[RATE_W-1:0];
		sb.max_rate = hi[RATE_W-1:0];
		settings++;
	endtask

	// receiver: random pause before each pop, plus the one long hold-off
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles > 0) begin
				gap            = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				gap = draw_gap();
			end
			@(negedge clk);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(rsp);
		end
	end

	// timeout that fails the run if it hangs, well beyond the worst case
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		sb             = new(SLEW_BUDGET);
		pace_free      = 1'b0;
		rx_hold_cycles = 0;
		settings       = 1;
		arst_n         = 1'b0;
		push           = 1'b0;
		req            = '0;
		pop            = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset limits: field extremes and the named corner cases
		send_request(32'd0, 10'd0);                   // zero sense
		send_request(32'hFFFF_FFFF, 10'h3FF);         // clamp to max, one step down
		send_request(32'd100_000_000, 10'd100);       // already at target
		send_request(32'd1_020_000_000, 10'd25);      // step limit going up
		send_request(32'd5_000_000, 10'd1023);        // step limit going down
		send_request(32'd100_000_000, 10'd1);         // upward step stalls
		send_request(32'd2_499_999, 10'd7);           // clamp to min, downward step stalls
		send_request(32'd102_500_000, 10'd90);        // exact half step rounds down
		send_request(32'd102_500_001, 10'd120);       // just past half step rounds up
		send_request(32'd37_000_000, 10'd36);         // single short step down
		send_request(32'd500_000_000, 10'd300);
		send_request(32'd400_000_000, 10'd900);
		send_request(32'd0, 10'd1023);
		send_request(32'h8000_0000, 10'd512);
		send_request(32'h5555_5555, 10'h2AA);
		send_request(32'hAAAA_AAAA, 10'h155);
		run_requests(70);
		settle();

		// min above max, both at their extremes: max wins
		set_rates(32'd1_020_000_000, 32'd5_000_000);
		send_request(32'd600_000_000, 10'd600);
		run_requests(50);
		settle();

		// limits off the 5 mhz grid, no idling on either side
		pace_free = 1'b1;
		set_rates(32'd250_000_003, 32'd700_000_001);
		run_requests(70);
		settle();
		pace_free = 1'b0;

		// full 30-bit max, so rounding up would overflow and falls back
		set_rates(32'd5_000_000, MASK30);
		send_request(32'hFFFF_FFFF, 10'd1023);
		send_request(32'd1_072_500_001, 10'd1000);
		// receiver stalls for a long while so the block backs up into full
		rx_hold_cycles = 300;
		run_requests(60);
		settle();

		// random limits, sender drains the block half way through
		set_rates($urandom_range(5_000_000, 1_020_000_000),
			$urandom_range(5_000_000, 1_020_000_000));
		run_requests(35);
		settle();
		run_requests(35);
		settle();

		set_rates($urandom_range(5_000_000, 1_020_000_000),
			$urandom_range(5_000_000, 1_020_000_000));
		run_requests(70);
		settle();

		set_rates(32'd5_000_000, 32'd1_020_000_000);
		run_requests(90);
		settle();

		$display("covered %0d requests giving %0d results: %0d multiplier writes,",
			sb.requests, sb.results, sb.writes);
		$display("%0d flagged, %0d no-change, %0d rate limit settings, %0d mismatches",
			sb.flagged, sb.no_change, settings, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/prss_pkg.sv
rtl/prss_queue.sv
rtl/prss_front.sv
rtl/prss_back.sv
rtl/pll_rate_slew_sequencer.sv
sim/pll_rate_slew_sequencer_test.sv
